@@ src/subarray_xor_below_threshold_counter_top_macros.svh @@
// Assertion helpers for the subarray XOR counter.
`ifndef SUBARRAY_XOR_BELOW_THRESHOLD_COUNTER_TOP_MACROS_SVH
`define SUBARRAY_XOR_BELOW_THRESHOLD_COUNTER_TOP_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define SXBTC_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sxbtc assertion failed");
// next-cycle implication
`define SXBTC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sxbtc assertion failed");
`else
`define SXBTC_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define SXBTC_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

@@ src/sxbtc_pkg.sv @@
package sxbtc_pkg;

   localparam int ELEMENT_W   = 32;
   localparam int THRESHOLD_W = 32;
   localparam int HERE_W      = 11;
   localparam int TOTAL_W     = 20;

   localparam int DEF_KEY_BITS     = 32;
   localparam int DEF_MAX_ELEMENTS = 1024;
   localparam int DEF_NODE_COUNT   = 32768;

   typedef enum logic [1:0] {
      MODE_PROBE,
      MODE_QUERY,
      MODE_QUERY_ALL,
      MODE_INSERT
   } step_mode_type;

   typedef struct packed {
      logic [HERE_W-1:0]  ending_here;
      logic [TOTAL_W-1:0] running_total;
      logic               dropped;
   } rsp_beat_type;

endpackage

@@ src/sxbtc_req_if.sv @@
interface sxbtc_req_if import sxbtc_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [ELEMENT_W-1:0] element;
   logic                 first;

   modport source (output valid, output element, output first, input ready);
   modport sink (input valid, input element, input first, output ready);
endinterface

@@ src/sxbtc_rsp_if.sv @@
interface sxbtc_rsp_if import sxbtc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [HERE_W-1:0]  ending_here;
   logic [TOTAL_W-1:0] running_total;
   logic               dropped;

   modport source (output valid, output ending_here, output running_total, output dropped,
                   input ready);
   modport sink (input valid, input ending_here, input running_total, input dropped,
                 output ready);
endinterface

@@ src/sxbtc_ram.sv @@
module sxbtc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/sxbtc_step.sv @@
// One trie level: child select, count pick-up and node update.
module sxbtc_step import sxbtc_pkg::*; #(
   parameter int AW = 15,
   parameter int CW = 11,
   localparam int NW = 2 * AW + 2 * CW
) (
   input  step_mode_type mode,
   input  logic [NW-1:0] node,
   input  logic          key_bit,
   input  logic          thr_bit,
   input  logic [AW-1:0] new_idx,
   output logic [AW-1:0] nxt,
   output logic          absent,
   output logic [CW-1:0] add,
   output logic [NW-1:0] upd
);

   logic [CW-1:0] cnt0, cnt1;
   logic [AW-1:0] kid0, kid1;
   logic          dir;

   assign cnt0 = node[CW-1:0];
   assign cnt1 = node[2*CW-1:CW];
   assign kid0 = node[2*CW+AW-1:2*CW];
   assign kid1 = node[NW-1:2*CW+AW];

   always_comb begin
      dir = key_bit;
      add = '0;
      case (mode)
         MODE_QUERY: begin
            dir = key_bit ^ thr_bit;
            if (thr_bit) begin
               add = key_bit ? cnt1 : cnt0;
            end
         end
         MODE_QUERY_ALL: begin
            add = cnt0 + cnt1;
         end
         default: begin
         end
      endcase
      nxt    = dir ? kid1 : kid0;
      absent = (nxt == '0);
      if (key_bit) begin
         upd = {(absent ? new_idx : kid1), kid0, cnt1 + CW'(1), cnt0};
      end else begin
         upd = {kid1, (absent ? new_idx : kid0), cnt1, cnt0 + CW'(1)};
      end
   end

endmodule

@@ src/sxbtc_engine.sv @@
`include "subarray_xor_below_threshold_counter_top_macros.svh"
// Sequencer: probe walk, optional zero insert, query walk, insert walk.
module sxbtc_engine import sxbtc_pkg::*; #(
   parameter int KEY_BITS     = DEF_KEY_BITS,
   parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS,
   parameter int NODE_COUNT   = DEF_NODE_COUNT,
   localparam int AW = $clog2(NODE_COUNT),
   localparam int CW = $clog2(MAX_ELEMENTS + 2),
   localparam int NW = 2 * AW + 2 * CW
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [ELEMENT_W-1:0]   start_element,
   input  logic                   start_first,
   input  logic [THRESHOLD_W-1:0] threshold,
   input  logic                   out_free,
   output logic                   idle,
   output logic                   done,
   output rsp_beat_type           beat,
   output logic                   rd_en,
   output logic [AW-1:0]          rd_addr,
   input  logic [NW-1:0]          rd_data,
   output logic                   wr_en,
   output logic [AW-1:0]          wr_addr,
   output logic [NW-1:0]          wr_data
);

   localparam int LW   = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
   localparam int MW   = $clog2(KEY_BITS + 1);
   localparam int NDW  = $clog2(2 * KEY_BITS + 1);
   localparam int SW   = $clog2(MAX_ELEMENTS + 1);
   localparam int FW   = $clog2(NODE_COUNT + 1);
   localparam int CMPW = ((FW > NDW) ? FW : NDW) + 1;

   localparam logic [LW-1:0]   LAST_LEVEL = LW'(KEY_BITS - 1);
   localparam logic [NDW-1:0]  KEY_BITS_N = NDW'(KEY_BITS);
   localparam logic [SW-1:0]   MAX_SEEN   = SW'(MAX_ELEMENTS);
   localparam logic [CMPW-1:0] NODE_LIMIT = CMPW'(NODE_COUNT);
   // empty trie seen as a chain of zero children
   localparam logic [NW-1:0]   VIRT_NODE  = NW'(1) << (2 * CW);

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_CLEAR,
      ST_PSTART,
      ST_PROBE,
      ST_DECIDE,
      ST_QSTART,
      ST_QWALK,
      ST_ISTART,
      ST_IWALK,
      ST_FINISH
   } state_type;

   state_type           state_ff, state_in;
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [KEY_BITS-1:0] prefix_ff, prefix_in;
   logic                fresh_ff, fresh_in;
   logic [LW-1:0]       level_ff, level_in;
   logic [AW-1:0]       cur_ff, cur_in;
   logic                alloc_ff, alloc_in;
   logic                ins_zero_ff, ins_zero_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic [MW-1:0]       missing_ff, missing_in;
   logic                drop_ff, drop_in;
   logic [SW-1:0]       seen_ff, seen_in;
   logic [TOTAL_W-1:0]  total_ff, total_in;
   logic [FW-1:0]       free_ff, free_in;

   step_mode_type       step_mode;
   logic [NW-1:0]       step_node;
   logic                step_key;
   logic [AW-1:0]       step_nxt;
   logic                step_absent;
   logic [CW-1:0]       step_add;
   logic [NW-1:0]       step_upd;
   logic [NDW-1:0]      need;
   logic                thr_wide;

   sxbtc_step #(
      .AW (AW),
      .CW (CW)
   ) u_step (
      .mode    (step_mode),
      .node    (step_node),
      .key_bit (step_key),
      .thr_bit (threshold[level_ff]),
      .new_idx (free_ff[AW-1:0]),
      .nxt     (step_nxt),
      .absent  (step_absent),
      .add     (step_add),
      .upd     (step_upd)
   );

   assign thr_wide = ((threshold >> KEY_BITS) != '0);
   assign need     = fresh_ff ? (KEY_BITS_N + NDW'(missing_ff)) : NDW'(missing_ff);
   assign idle     = (state_ff == ST_IDLE);

   assign beat.ending_here   = HERE_W'(cnt_ff);
   assign beat.running_total = total_ff;
   assign beat.dropped       = drop_ff;

   always_comb begin
      state_in    = state_ff;
      key_in      = key_ff;
      prefix_in   = prefix_ff;
      fresh_in    = fresh_ff;
      level_in    = level_ff;
      cur_in      = cur_ff;
      alloc_in    = alloc_ff;
      ins_zero_in = ins_zero_ff;
      cnt_in      = cnt_ff;
      missing_in  = missing_ff;
      drop_in     = drop_ff;
      seen_in     = seen_ff;
      total_in    = total_ff;
      free_in     = free_ff;
      rd_en       = 1'b0;
      rd_addr     = '0;
      wr_en       = 1'b0;
      wr_addr     = '0;
      wr_data     = '0;
      done        = 1'b0;
      step_mode   = MODE_PROBE;
      step_node   = rd_data;
      step_key    = key_ff[level_ff];
      case (state_ff)
         ST_INIT: begin
            wr_en    = 1'b1;
            state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) begin
               drop_in  = 1'b0;
               cnt_in   = '0;
               fresh_in = start_first || (seen_ff == '0);
               if (start_first) begin
                  key_in    = start_element[KEY_BITS-1:0];
                  prefix_in = '0;
                  seen_in   = '0;
                  total_in  = '0;
                  free_in   = FW'(1);
                  state_in  = ST_CLEAR;
               end else begin
                  key_in = prefix_ff ^ start_element[KEY_BITS-1:0];
                  if (seen_ff >= MAX_SEEN) begin
                     drop_in  = 1'b1;
                     state_in = ST_FINISH;
                  end else begin
                     state_in = ST_PSTART;
                  end
               end
            end
         end
         ST_CLEAR: begin
            wr_en    = 1'b1;
            state_in = ST_PSTART;
         end
         ST_PSTART: begin
            rd_en    = !fresh_ff;
            level_in = LAST_LEVEL;
            state_in = ST_PROBE;
         end
         ST_PROBE: begin
            if (fresh_ff) begin
               step_node = VIRT_NODE;
            end
            if (step_absent) begin
               missing_in = MW'(level_ff) + MW'(1);
               state_in   = ST_DECIDE;
            end else if (level_ff == '0) begin
               missing_in = '0;
               state_in   = ST_DECIDE;
            end else begin
               rd_en    = !fresh_ff;
               rd_addr  = step_nxt;
               level_in = level_ff - LW'(1);
            end
         end
         ST_DECIDE: begin
            if ((CMPW'(need) + CMPW'(free_ff)) > NODE_LIMIT) begin
               drop_in  = 1'b1;
               state_in = ST_FINISH;
            end else if (fresh_ff) begin
               ins_zero_in = 1'b1;
               state_in    = ST_ISTART;
            end else begin
               state_in = ST_QSTART;
            end
         end
         ST_QSTART: begin
            rd_en    = 1'b1;
            level_in = LAST_LEVEL;
            cnt_in   = '0;
            state_in = ST_QWALK;
         end
         ST_QWALK: begin
            step_mode = thr_wide ? MODE_QUERY_ALL : MODE_QUERY;
            cnt_in    = cnt_ff + step_add;
            if (thr_wide || step_absent || (level_ff == '0)) begin
               ins_zero_in = 1'b0;
               state_in    = ST_ISTART;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = step_nxt;
               level_in = level_ff - LW'(1);
            end
         end
         ST_ISTART: begin
            rd_en    = 1'b1;
            level_in = LAST_LEVEL;
            cur_in   = '0;
            alloc_in = 1'b0;
            state_in = ST_IWALK;
         end
         ST_IWALK: begin
            step_mode = MODE_INSERT;
            if (alloc_ff) begin
               step_node = '0;
            end
            if (ins_zero_ff) begin
               step_key = 1'b0;
            end
            wr_en   = 1'b1;
            wr_addr = cur_ff;
            wr_data = step_upd;
            if (step_absent) begin
               cur_in   = free_ff[AW-1:0];
               free_in  = free_ff + FW'(1);
               alloc_in = 1'b1;
            end else begin
               cur_in  = step_nxt;
               rd_en   = (level_ff != '0);
               rd_addr = step_nxt;
            end
            if (level_ff == '0) begin
               if (ins_zero_ff) begin
                  state_in = ST_QSTART;
               end else begin
                  prefix_in = key_ff;
                  seen_in   = seen_ff + SW'(1);
                  total_in  = total_ff + TOTAL_W'(cnt_ff);
                  state_in  = ST_FINISH;
               end
            end else begin
               level_in = level_ff - LW'(1);
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               done     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_INIT;
         prefix_ff   <= '0;
         seen_ff     <= '0;
         total_ff    <= '0;
         free_ff     <= FW'(1);
         fresh_ff    <= 1'b0;
         alloc_ff    <= 1'b0;
         ins_zero_ff <= 1'b0;
         drop_ff     <= 1'b0;
      end else begin
         state_ff    <= state_in;
         prefix_ff   <= prefix_in;
         seen_ff     <= seen_in;
         total_ff    <= total_in;
         free_ff     <= free_in;
         fresh_ff    <= fresh_in;
         alloc_ff    <= alloc_in;
         ins_zero_ff <= ins_zero_in;
         drop_ff     <= drop_in;
         key_ff      <= key_in;
         level_ff    <= level_in;
         cur_ff      <= cur_in;
         cnt_ff      <= cnt_in;
         missing_ff  <= missing_in;
      end
   end

   `SXBTC_ASSERT_SAME(a_no_rw_clash, clock, reset, wr_en && rd_en, wr_addr != rd_addr)
   `SXBTC_ASSERT_NEXT(a_alloc_sticks, clock, reset, (state_ff == ST_IWALK) && alloc_ff && (level_ff != '0), alloc_ff)
   `SXBTC_ASSERT_SAME(a_idle_bounds, clock, reset, state_ff == ST_IDLE, (CMPW'(free_ff) <= NODE_LIMIT) && (seen_ff <= MAX_SEEN))

endmodule

@@ src/subarray_xor_below_threshold_counter_top.sv @@
// Counts, for each word of a sequence, the subarrays ending at that word whose XOR is below
// the threshold register, and keeps the running total. Earlier prefix XORs live in a binary
// trie in one node memory with a single read port and a registered read. A word takes a
// probe walk, which may stop early at a missing child, then a query walk and an insert
// walk; the first word of a sequence also inserts prefix zero before its query walk, and
// the root is cleared first when first is set. A word dropped for the element limit goes
// from idle straight to finish; one dropped for lack of trie nodes ends after the probe
// walk. The root is written in the init state entered on reset. req ready is high only
// between words; a result is held in an output register so the next word may start while
// it waits.
`include "subarray_xor_below_threshold_counter_top_macros.svh"
module subarray_xor_below_threshold_counter_top import sxbtc_pkg::*; #(
   parameter int KEY_BITS     = DEF_KEY_BITS,
   parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS,
   parameter int NODE_COUNT   = DEF_NODE_COUNT
) (
   input  logic                   clock,
   input  logic                   reset,
   sxbtc_req_if.sink              req_bus,
   sxbtc_rsp_if.source            rsp_bus,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [THRESHOLD_W-1:0] csr_wdata
);

   localparam int AW = $clog2(NODE_COUNT);
   localparam int CW = $clog2(MAX_ELEMENTS + 2);
   localparam int NW = 2 * AW + 2 * CW;

   logic [THRESHOLD_W-1:0] threshold_ff, threshold_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_beat_type           beat_ff, beat_in;

   logic                   start;
   logic                   out_free;
   logic                   eng_idle;
   logic                   eng_done;
   rsp_beat_type           eng_beat;
   logic                   rd_en;
   logic [AW-1:0]          rd_addr;
   logic [NW-1:0]          rd_data;
   logic                   wr_en;
   logic [AW-1:0]          wr_addr;
   logic [NW-1:0]          wr_data;

   assign csr_ready     = 1'b1;
   assign threshold_in  = csr_valid ? csr_wdata : threshold_ff;
   assign req_bus.ready = eng_idle;
   assign start         = req_bus.valid && eng_idle;
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;

   sxbtc_engine #(
      .KEY_BITS     (KEY_BITS),
      .MAX_ELEMENTS (MAX_ELEMENTS),
      .NODE_COUNT   (NODE_COUNT)
   ) u_engine (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .start_element (req_bus.element),
      .start_first   (req_bus.first),
      .threshold     (threshold_ff),
      .out_free      (out_free),
      .idle          (eng_idle),
      .done          (eng_done),
      .beat          (eng_beat),
      .rd_en         (rd_en),
      .rd_addr       (rd_addr),
      .rd_data       (rd_data),
      .wr_en         (wr_en),
      .wr_addr       (wr_addr),
      .wr_data       (wr_data)
   );

   sxbtc_ram #(
      .WIDTH (NW),
      .DEPTH (NODE_COUNT)
   ) u_node_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // output beat register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      beat_in      = beat_ff;
      if (eng_done) begin
         rsp_valid_in = 1'b1;
         beat_in      = eng_beat;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         threshold_ff <= threshold_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      beat_ff <= beat_in;
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.ending_here   = beat_ff.ending_here;
   assign rsp_bus.running_total = beat_ff.running_total;
   assign rsp_bus.dropped       = beat_ff.dropped;

   `SXBTC_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_bus.valid && req_bus.ready, !req_bus.ready)
   `SXBTC_ASSERT_SAME(a_done_has_room, clock, reset, eng_done, !rsp_valid_ff || rsp_bus.ready)
   `SXBTC_ASSERT_NEXT(a_rsp_held, clock, reset, rsp_bus.valid && !rsp_bus.ready, rsp_bus.valid)

endmodule
